// ===== rtl/core/rhr_pkg.sv =====
// ----------------------------------------------------------------------------
// rhr_pkg: shared types and constants for the RGB hue rotation pipeline
// Pixel and hue widths, hue sector bases, divider staging and the
// transaction record that travels from the front stage through the divider.
// ----------------------------------------------------------------------------
`default_nettype none

package rhr_pkg;

    localparam int unsigned PIX_W   = 8;
    localparam int unsigned HUE_W   = 11;
    localparam int unsigned QUO_W   = 9;

    // Hue units: 256 per sixth of a turn, 1536 per full turn
    localparam logic [HUE_W-1:0] HUE_TURN   = 11'd1536;
    localparam logic [HUE_W-1:0] BASE_RED   = 11'd0;
    localparam logic [HUE_W-1:0] BASE_GREEN = 11'd512;
    localparam logic [HUE_W-1:0] BASE_BLUE  = 11'd1024;

    // Divider: one leading quotient bit, then eight bits over four stages
    localparam int unsigned DIV_STAGES = 4;
    localparam int unsigned DIV_STEPS  = 2;

    // Accept edge to the edge that samples the result strobe
    localparam int unsigned LATENCY = 9;

    // Hue sectors, each 60 degrees wide
    typedef enum logic [2:0] {
        SEC_RY = 3'd0,
        SEC_YG = 3'd1,
        SEC_GC = 3'd2,
        SEC_CB = 3'd3,
        SEC_BM = 3'd4,
        SEC_MR = 3'd5
    } sector_t;

    // Per-transaction record from the front stage through the divider
    typedef struct packed {
        logic [PIX_W-1:0] chroma;
        logic [PIX_W-1:0] minv;
        logic [HUE_W-1:0] base;
        logic             neg;
        logic [PIX_W-1:0] rem;
        logic [QUO_W-1:0] quo;
    } rhr_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/rgb_hue_rotation.sv =====
// ----------------------------------------------------------------------------
// rgb_hue_rotation: per-pixel hue rotation of 8-bit RGB
// Converts to chroma, minimum and hue, adds a configured hue shift and
// rebuilds RGB, one pixel per clock through a nine-stage pipeline.
// ----------------------------------------------------------------------------
//
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------------
//  pixel in | start, busy         | red_in, green_in, blue_in
//  pixel out| done (strobe)       | red_out, green_out, blue_out
//  config   | cfg_we              | cfg_wdata (hue shift, 1536 per turn)
//
//  One pixel enters per cycle; busy stays low since nothing can stall.
//  Nine register stages: the front stage, four divider stages (the first
//  resolves the leading quotient bit plus two more, the others two each)
//  and four rebuild stages. The strobe is the valid bit of the last rebuild
//  stage. Reset clears all valid bits and the shift to zero. Results are
//  presented for exactly one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_hue_rotation (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [rhr_pkg::PIX_W-1:0]   red_in,
    input  wire logic [rhr_pkg::PIX_W-1:0]   green_in,
    input  wire logic [rhr_pkg::PIX_W-1:0]   blue_in,
    output logic                             done,
    output logic [rhr_pkg::PIX_W-1:0]        red_out,
    output logic [rhr_pkg::PIX_W-1:0]        green_out,
    output logic [rhr_pkg::PIX_W-1:0]        blue_out,
    input  wire logic                        cfg_we,
    input  wire logic [rhr_pkg::HUE_W-1:0]   cfg_wdata
);

    logic [rhr_pkg::HUE_W-1:0] shift_reg;
    logic [rhr_pkg::HUE_W-1:0] shift_next;
    logic                      accept;
    logic                      front_valid;
    rhr_pkg::rhr_item_t        front_item;
    logic                      div_valid;
    rhr_pkg::rhr_item_t        div_item;

    // Never stall the pixel stream
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Hold the shift reduced into one turn
    always_comb
    begin
        shift_next = shift_reg;
        if (cfg_we)
        begin
            if (cfg_wdata >= rhr_pkg::HUE_TURN)
            begin
                shift_next = cfg_wdata - rhr_pkg::HUE_TURN;
            end
            else
            begin
                shift_next = cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= '0;
        end
        else
        begin
            shift_reg <= shift_next;
        end
    end

    rhr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .red       (red_in),
        .green     (green_in),
        .blue      (blue_in),
        .out_valid (front_valid),
        .out_item  (front_item)
    );

    rhr_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_item   (front_item),
        .out_valid (div_valid),
        .out_item  (div_item)
    );

    rhr_rebuild u_rebuild (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .in_item   (div_item),
        .shift     (shift_reg),
        .out_valid (done),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out)
    );

`ifndef SYNTHESIS
    // Every accepted transaction yields a strobe after the pipeline latency
    a_accept_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##(rhr_pkg::LATENCY) done)
        else $error("accepted pixel produced no result strobe");

    // No strobe without a matching accepted transaction
    a_done_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, rhr_pkg::LATENCY))
        else $error("result strobe without accepted pixel");

    // Grey pixels pass through unchanged
    a_grey_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && red_in == green_in && green_in == blue_in)
        |-> ##(rhr_pkg::LATENCY)
        (red_out == $past(red_in, rhr_pkg::LATENCY)
         && green_out == $past(green_in, rhr_pkg::LATENCY)
         && blue_out == $past(blue_in, rhr_pkg::LATENCY)))
        else $error("grey pixel altered");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/rhr_front.sv =====
// ----------------------------------------------------------------------------
// rhr_front: max, min, chroma and hue operand selection
// Registers one transaction per cycle with the chroma, the minimum, the
// sector base and the absolute channel difference that seeds the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module rhr_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire logic [rhr_pkg::PIX_W-1:0]   red,
    input  wire logic [rhr_pkg::PIX_W-1:0]   green,
    input  wire logic [rhr_pkg::PIX_W-1:0]   blue,
    output logic                             out_valid,
    output rhr_pkg::rhr_item_t               out_item
);

    logic                      valid_reg;
    rhr_pkg::rhr_item_t        item_reg;
    rhr_pkg::rhr_item_t        item_next;
    logic [rhr_pkg::PIX_W-1:0] mx;
    logic [rhr_pkg::PIX_W-1:0] mn;
    logic [rhr_pkg::PIX_W-1:0] op_a;
    logic [rhr_pkg::PIX_W-1:0] op_b;

    // Find extremes; ties go to red, then green
    always_comb
    begin
        mx = red;
        if (green > mx)
        begin
            mx = green;
        end
        if (blue > mx)
        begin
            mx = blue;
        end
        mn = red;
        if (green < mn)
        begin
            mn = green;
        end
        if (blue < mn)
        begin
            mn = blue;
        end
    end

    // Select the two channels that set the hue within its sector
    always_comb
    begin
        item_next.chroma = mx - mn;
        item_next.minv   = mn;
        if (mx == red)
        begin
            op_a           = green;
            op_b           = blue;
            item_next.base = rhr_pkg::BASE_RED;
        end
        else if (mx == green)
        begin
            op_a           = blue;
            op_b           = red;
            item_next.base = rhr_pkg::BASE_GREEN;
        end
        else
        begin
            op_a           = red;
            op_b           = green;
            item_next.base = rhr_pkg::BASE_BLUE;
        end
        item_next.neg = (op_a < op_b);
        item_next.rem = item_next.neg ? (op_b - op_a) : (op_a - op_b);
        item_next.quo = '0;
    end

    // Advance valid with reset, payload without
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

// ===== rtl/core/rhr_divider.sv =====
// ----------------------------------------------------------------------------
// rhr_divider: pipelined restoring divider for difference * 256 / chroma
// The difference never exceeds chroma, so the quotient is at most 256.
// The first stage resolves the leading quotient bit; every stage then
// retires two more bits. A grey pixel (chroma zero) yields a quotient
// that does not matter, since chroma and ramp are then zero in every channel.
// ----------------------------------------------------------------------------
`default_nettype none

module rhr_divider (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire rhr_pkg::rhr_item_t   in_item,
    output logic                      out_valid,
    output rhr_pkg::rhr_item_t        out_item
);

    logic               valid_reg [rhr_pkg::DIV_STAGES];
    rhr_pkg::rhr_item_t item_reg  [rhr_pkg::DIV_STAGES];
    rhr_pkg::rhr_item_t item_next [rhr_pkg::DIV_STAGES];

    // Leading bit: remainder starts at most equal to chroma
    function automatic rhr_pkg::rhr_item_t div_first(input rhr_pkg::rhr_item_t it);
        rhr_pkg::rhr_item_t r;
        r = it;
        if (it.rem >= it.chroma)
        begin
            r.rem = it.rem - it.chroma;
            r.quo = {{(rhr_pkg::QUO_W-1){1'b0}}, 1'b1};
        end
        else
        begin
            r.quo = '0;
        end
        return r;
    endfunction

    // One restoring step: shift, compare, subtract
    function automatic rhr_pkg::rhr_item_t div_step(input rhr_pkg::rhr_item_t it);
        rhr_pkg::rhr_item_t   r;
        logic [rhr_pkg::PIX_W:0] sh;
        r  = it;
        sh = {it.rem, 1'b0};
        if (sh >= {1'b0, it.chroma})
        begin
            r.rem = rhr_pkg::PIX_W'(sh - {1'b0, it.chroma});
            r.quo = {it.quo[rhr_pkg::QUO_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = sh[rhr_pkg::PIX_W-1:0];
            r.quo = {it.quo[rhr_pkg::QUO_W-2:0], 1'b0};
        end
        return r;
    endfunction

    for (genvar s = 0; s < rhr_pkg::DIV_STAGES; s++)
    begin : g_stage
        rhr_pkg::rhr_item_t cur;
        logic               vin;

        if (s == 0)
        begin : g_head
            always_comb
            begin
                cur = div_first(in_item);
                vin = in_valid;
            end
        end
        else
        begin : g_body
            always_comb
            begin
                cur = item_reg[s-1];
                vin = valid_reg[s-1];
            end
        end

        // Retire this stage's quotient bits
        always_comb
        begin
            item_next[s] = cur;
            for (int k = 0; k < rhr_pkg::DIV_STEPS; k++)
            begin
                item_next[s] = div_step(item_next[s]);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else
            begin
                valid_reg[s] <= vin;
            end
        end

        always_ff @(posedge clk)
        begin
            item_reg[s] <= item_next[s];
        end
    end

    assign out_valid = valid_reg[rhr_pkg::DIV_STAGES-1];
    assign out_item  = item_reg[rhr_pkg::DIV_STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/core/rhr_rebuild.sv =====
// ----------------------------------------------------------------------------
// rhr_rebuild: hue wrap, rotation and RGB reconstruction
// Stage A folds the signed quotient into 0..1535, stage B adds the shift,
// stage C forms the rounded ramp value, stage D places chroma, ramp and
// zero by sector and adds the minimum back.
// ----------------------------------------------------------------------------
`default_nettype none

module rhr_rebuild (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire rhr_pkg::rhr_item_t          in_item,
    input  wire logic [rhr_pkg::HUE_W-1:0]   shift,
    output logic                             out_valid,
    output logic [rhr_pkg::PIX_W-1:0]        red_out,
    output logic [rhr_pkg::PIX_W-1:0]        green_out,
    output logic [rhr_pkg::PIX_W-1:0]        blue_out
);

    localparam int unsigned SUM_W  = rhr_pkg::HUE_W + 1;
    localparam int unsigned PROD_W = 2 * rhr_pkg::PIX_W + 1;
    localparam logic [SUM_W-1:0]  TURN_X   = SUM_W'(rhr_pkg::HUE_TURN);
    localparam logic [rhr_pkg::PIX_W:0] SIXTH = 9'd256;
    localparam logic [PROD_W-1:0] ROUND_HALF = 17'd128;

    // Stage A registers
    logic                       a_valid_reg;
    logic [rhr_pkg::HUE_W-1:0]  a_hue_reg;
    logic [rhr_pkg::HUE_W-1:0]  a_hue_next;
    logic [rhr_pkg::PIX_W-1:0]  a_chroma_reg;
    logic [rhr_pkg::PIX_W-1:0]  a_minv_reg;
    // Stage B registers
    logic                       b_valid_reg;
    logic [rhr_pkg::HUE_W-1:0]  b_hue_reg;
    logic [rhr_pkg::HUE_W-1:0]  b_hue_next;
    logic [rhr_pkg::PIX_W-1:0]  b_chroma_reg;
    logic [rhr_pkg::PIX_W-1:0]  b_minv_reg;
    // Stage C registers
    logic                       c_valid_reg;
    rhr_pkg::sector_t           c_sector_reg;
    logic [rhr_pkg::PIX_W-1:0]  c_ramp_reg;
    logic [rhr_pkg::PIX_W-1:0]  c_ramp_next;
    logic [rhr_pkg::PIX_W-1:0]  c_chroma_reg;
    logic [rhr_pkg::PIX_W-1:0]  c_minv_reg;
    // Output registers
    logic                       d_valid_reg;
    logic [rhr_pkg::PIX_W-1:0]  d_red_reg;
    logic [rhr_pkg::PIX_W-1:0]  d_green_reg;
    logic [rhr_pkg::PIX_W-1:0]  d_blue_reg;
    logic [rhr_pkg::PIX_W-1:0]  d_red_next;
    logic [rhr_pkg::PIX_W-1:0]  d_green_next;
    logic [rhr_pkg::PIX_W-1:0]  d_blue_next;

    logic [SUM_W-1:0]           a_sum;
    logic [SUM_W-1:0]           b_sum;
    logic [rhr_pkg::PIX_W:0]    c_weight;
    logic [PROD_W-1:0]          c_prod;
    logic [rhr_pkg::PIX_W-1:0]  ro;
    logic [rhr_pkg::PIX_W-1:0]  go;
    logic [rhr_pkg::PIX_W-1:0]  bo;

    // Fold base plus or minus quotient into one turn
    always_comb
    begin
        if (in_item.neg)
        begin
            a_sum = SUM_W'(in_item.base) + TURN_X - SUM_W'(in_item.quo);
        end
        else
        begin
            a_sum = SUM_W'(in_item.base) + SUM_W'(in_item.quo);
        end
        if (a_sum >= TURN_X)
        begin
            a_hue_next = rhr_pkg::HUE_W'(a_sum - TURN_X);
        end
        else
        begin
            a_hue_next = a_sum[rhr_pkg::HUE_W-1:0];
        end
    end

    // Rotate by the configured shift, wrap once
    always_comb
    begin
        b_sum = SUM_W'(a_hue_reg) + SUM_W'(shift);
        if (b_sum >= TURN_X)
        begin
            b_hue_next = rhr_pkg::HUE_W'(b_sum - TURN_X);
        end
        else
        begin
            b_hue_next = b_sum[rhr_pkg::HUE_W-1:0];
        end
    end

    // Rounded ramp: rising in even sectors, falling in odd ones
    always_comb
    begin
        if (b_hue_reg[rhr_pkg::PIX_W])
        begin
            c_weight = SIXTH - {1'b0, b_hue_reg[rhr_pkg::PIX_W-1:0]};
        end
        else
        begin
            c_weight = {1'b0, b_hue_reg[rhr_pkg::PIX_W-1:0]};
        end
        c_prod      = PROD_W'(b_chroma_reg) * PROD_W'(c_weight) + ROUND_HALF;
        c_ramp_next = c_prod[2*rhr_pkg::PIX_W-1:rhr_pkg::PIX_W];
    end

    // Place chroma and ramp by sector, add the minimum back
    always_comb
    begin
        case (c_sector_reg)
            rhr_pkg::SEC_RY:
            begin
                ro = c_chroma_reg; go = c_ramp_reg;   bo = '0;
            end
            rhr_pkg::SEC_YG:
            begin
                ro = c_ramp_reg;   go = c_chroma_reg; bo = '0;
            end
            rhr_pkg::SEC_GC:
            begin
                ro = '0;           go = c_chroma_reg; bo = c_ramp_reg;
            end
            rhr_pkg::SEC_CB:
            begin
                ro = '0;           go = c_ramp_reg;   bo = c_chroma_reg;
            end
            rhr_pkg::SEC_BM:
            begin
                ro = c_ramp_reg;   go = '0;           bo = c_chroma_reg;
            end
            default:
            begin
                ro = c_chroma_reg; go = '0;           bo = c_ramp_reg;
            end
        endcase
        d_red_next   = ro + c_minv_reg;
        d_green_next = go + c_minv_reg;
        d_blue_next  = bo + c_minv_reg;
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        a_hue_reg    <= a_hue_next;
        a_chroma_reg <= in_item.chroma;
        a_minv_reg   <= in_item.minv;
        b_hue_reg    <= b_hue_next;
        b_chroma_reg <= a_chroma_reg;
        b_minv_reg   <= a_minv_reg;
        c_sector_reg <= rhr_pkg::sector_t'(b_hue_reg[rhr_pkg::HUE_W-1:rhr_pkg::PIX_W]);
        c_ramp_reg   <= c_ramp_next;
        c_chroma_reg <= b_chroma_reg;
        c_minv_reg   <= b_minv_reg;
        d_red_reg    <= d_red_next;
        d_green_reg  <= d_green_next;
        d_blue_reg   <= d_blue_next;
    end

    assign out_valid = d_valid_reg;
    assign red_out   = d_red_reg;
    assign green_out = d_green_reg;
    assign blue_out  = d_blue_reg;

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for rgb_hue_rotation
// A queue-fed driver presents pixels with random gaps, and a monitor predicts
// each rotated pixel at its accept edge and compares it with the result
// strobe. The hue shift is changed between drained phases.
// ----------------------------------------------------------------------------

module testbench;

    localparam int unsigned HUE_SIXTH = 256;
    localparam int unsigned NUM_PHASES = 11;
    localparam int unsigned ITEMS_PER_PHASE = 55;

    typedef struct packed {
        logic [rhr_pkg::PIX_W-1:0] red;
        logic [rhr_pkg::PIX_W-1:0] green;
        logic [rhr_pkg::PIX_W-1:0] blue;
    } pixel_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic [rhr_pkg::PIX_W-1:0] red_in = '0;
    logic [rhr_pkg::PIX_W-1:0] green_in = '0;
    logic [rhr_pkg::PIX_W-1:0] blue_in = '0;
    logic                      done;
    logic [rhr_pkg::PIX_W-1:0] red_out;
    logic [rhr_pkg::PIX_W-1:0] green_out;
    logic [rhr_pkg::PIX_W-1:0] blue_out;
    logic                      cfg_we = 1'b0;
    logic [rhr_pkg::HUE_W-1:0] cfg_wdata = '0;

    pixel_t                    pixel_q[$];
    pixel_t                    rotated_q[$];
    logic [rhr_pkg::HUE_W-1:0] hue_shift = '0;
    logic                      in_taken = 1'b0;
    int                        gap_left = 0;
    bit                        no_gaps = 1'b0;
    int                        err_count = 0;

    rgb_hue_rotation u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .done      (done),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // Hue term (a - b) * 256 / c truncated toward zero, offset and wrapped
    function automatic int unsigned hue_from_diff(int unsigned a, int unsigned b,
                                                  int unsigned c, int unsigned base);
        int unsigned q;
        int unsigned turn;
        turn = rhr_pkg::HUE_TURN;
        if (a >= b)
        begin
            q = ((a - b) * HUE_SIXTH) / c;
            return (base + q) % turn;
        end
        q = ((b - a) * HUE_SIXTH) / c;
        return (base + turn - q) % turn;
    endfunction

    // Rotate the hue of one pixel by the given shift
    function automatic pixel_t rotate_pixel(pixel_t p, logic [rhr_pkg::HUE_W-1:0] shift);
        int unsigned r, g, b, mx, mn, c, h, frac, ramp, ro, go, bo, turn;
        pixel_t      o;
        turn = rhr_pkg::HUE_TURN;
        r = p.red;
        g = p.green;
        b = p.blue;
        mx = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        c = mx - mn;
        // Grey passes through
        if (c == 0)
            return p;
        // Red wins ties over green, green over blue
        if (mx == r)
            h = hue_from_diff(g, b, c, rhr_pkg::BASE_RED);
        else if (mx == g)
            h = hue_from_diff(b, r, c, rhr_pkg::BASE_GREEN);
        else
            h = hue_from_diff(r, g, c, rhr_pkg::BASE_BLUE);
        h = (h + (32'(shift) % turn)) % turn;
        frac = h & 32'hFF;
        if (((h >> 8) & 1) == 0)
            ramp = (c * frac + 128) >> 8;
        else
            ramp = (c * (HUE_SIXTH - frac) + 128) >> 8;
        case (rhr_pkg::sector_t'(3'(h >> 8)))
            rhr_pkg::SEC_RY: begin ro = c;    go = ramp; bo = 0;    end
            rhr_pkg::SEC_YG: begin ro = ramp; go = c;    bo = 0;    end
            rhr_pkg::SEC_GC: begin ro = 0;    go = c;    bo = ramp; end
            rhr_pkg::SEC_CB: begin ro = 0;    go = ramp; bo = c;    end
            rhr_pkg::SEC_BM: begin ro = ramp; go = 0;    bo = c;    end
            default:         begin ro = c;    go = 0;    bo = ramp; end
        endcase
        o.red   = rhr_pkg::PIX_W'(ro + mn);
        o.green = rhr_pkg::PIX_W'(go + mn);
        o.blue  = rhr_pkg::PIX_W'(bo + mn);
        return o;
    endfunction

    // Mostly back-to-back or short gaps, now and then a long one
    function automatic int pick_gap();
        if (no_gaps)
            return 0;
        if ($urandom_range(0, 11) == 0)
            return $urandom_range(6, 30);
        if ($urandom_range(0, 2) == 0)
            return $urandom_range(1, 3);
        return 0;
    endfunction

    // Random pixel, biased toward greys, ties, tiny chroma and wrapped hues
    function automatic pixel_t make_pixel();
        int unsigned hi, lo, pick;
        pixel_t      p;
        pick = $urandom_range(0, 2);
        hi = $urandom_range(1, 255);
        lo = $urandom_range(0, hi - 1);
        case ($urandom_range(0, 9))
            5: p = {3{rhr_pkg::PIX_W'($urandom_range(0, 255))}};
            6:
            begin
                p = {3{rhr_pkg::PIX_W'(hi)}};
                if (pick == 0) p.red = rhr_pkg::PIX_W'(lo);
                else if (pick == 1) p.green = rhr_pkg::PIX_W'(lo);
                else p.blue = rhr_pkg::PIX_W'(lo);
            end
            7:
            begin
                lo = $urandom_range(0, 251);
                p.red   = rhr_pkg::PIX_W'(lo + $urandom_range(0, 3));
                p.green = rhr_pkg::PIX_W'(lo + $urandom_range(0, 3));
                p.blue  = rhr_pkg::PIX_W'(lo + $urandom_range(0, 3));
            end
            8:
            begin
                p.red   = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'd255;
                p.green = ($urandom_range(0, 2) == 0) ? 8'd0 : rhr_pkg::PIX_W'($urandom);
                p.blue  = ($urandom_range(0, 1) == 0) ? 8'd255 : rhr_pkg::PIX_W'($urandom);
            end
            9:
            begin
                // Red maximum with green below blue gives a negative hue
                p.red   = rhr_pkg::PIX_W'(hi);
                p.blue  = rhr_pkg::PIX_W'($urandom_range(0, hi - 1));
                p.green = rhr_pkg::PIX_W'($urandom_range(0, 32'(p.blue)));
                if (p.green == p.blue && p.blue != 0) p.green = p.blue - 8'd1;
            end
            default: p = pixel_t'($urandom);
        endcase
        return p;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        err_count++;
    endtask

    // Hold until every queued pixel is accepted and every result is back
    task automatic wait_drained();
        while (pixel_q.size() != 0 || start || rotated_q.size() != 0)
        begin
            @(posedge clk);
            #1;
        end
    endtask

    task automatic write_hue_shift(input logic [rhr_pkg::HUE_W-1:0] value);
        @(negedge clk);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Drive pixels on the falling edge; hold a pixel until it is taken
    always @(negedge clk)
    begin : drive_proc
        pixel_t p;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (start && !in_taken)
        begin
            start <= 1'b1;
        end
        else if (gap_left > 0)
        begin
            start    <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else if (pixel_q.size() != 0)
        begin
            p = pixel_q.pop_front();
            start    <= 1'b1;
            red_in   <= p.red;
            green_in <= p.green;
            blue_in  <= p.blue;
            gap_left <= pick_gap();
        end
        else
        begin
            start <= 1'b0;
        end
    end

    // Check results, predict accepted pixels and track the shift register
    always @(posedge clk)
    begin : monitor_proc
        pixel_t want;
        pixel_t got;
        if (!rst_n)
        begin
            in_taken <= 1'b0;
        end
        else
        begin
            if (done)
            begin
                got = {red_out, green_out, blue_out};
                if (rotated_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result %h", got));
                end
                else
                begin
                    want = rotated_q.pop_front();
                    if (got.red !== want.red)
                        report_mismatch($sformatf("red_out %0d, want %0d",
                                                  got.red, want.red));
                    if (got.green !== want.green)
                        report_mismatch($sformatf("green_out %0d, want %0d",
                                                  got.green, want.green));
                    if (got.blue !== want.blue)
                        report_mismatch($sformatf("blue_out %0d, want %0d",
                                                  got.blue, want.blue));
                end
            end
            in_taken <= start && !busy;
            if (start && !busy)
                rotated_q.push_back(rotate_pixel({red_in, green_in, blue_in}, hue_shift));
            if (cfg_we)
                hue_shift <= cfg_wdata;
        end
    end

    // Phase sequence: directed pixels at reset shift, then random phases
    initial
    begin : stimulus_proc
        logic [rhr_pkg::HUE_W-1:0] shifts [NUM_PHASES];
        pixel_t                    directed [$];
        shifts = '{11'd2047, 11'd1536, 11'd1535, 11'd0, 11'd1, 11'd255, 11'd256,
                   11'd768, 11'd1280, 11'd0, 11'd0};
        shifts[9]  = rhr_pkg::HUE_W'($urandom_range(0, 2047));
        shifts[10] = rhr_pkg::HUE_W'($urandom_range(0, 2047));
        directed = '{
            {8'd0, 8'd0, 8'd0}, {8'd255, 8'd255, 8'd255}, {8'd128, 8'd128, 8'd128},
            {8'd255, 8'd0, 8'd0}, {8'd0, 8'd255, 8'd0}, {8'd0, 8'd0, 8'd255},
            {8'd255, 8'd255, 8'd0}, {8'd0, 8'd255, 8'd255}, {8'd255, 8'd0, 8'd255},
            {8'd200, 8'd200, 8'd10}, {8'd10, 8'd200, 8'd200}, {8'd200, 8'd10, 8'd200},
            {8'd255, 8'd0, 8'd1}, {8'd200, 8'd10, 8'd180},
            {8'd1, 8'd0, 8'd0}, {8'd0, 8'd0, 8'd1}, {8'd254, 8'd255, 8'd255},
            {8'd255, 8'd128, 8'd0}, {8'd17, 8'd240, 8'd99}, {8'd1, 8'd2, 8'd3},
            {8'd255, 8'd254, 8'd0}
        };
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            pixel_q.push_back(directed[i]);
        wait_drained();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            repeat (rhr_pkg::LATENCY) @(posedge clk);
            write_hue_shift(shifts[ph]);
            no_gaps = ($urandom_range(0, 3) == 0);
            repeat (ITEMS_PER_PHASE)
                pixel_q.push_back(make_pixel());
            wait_drained();
        end

        repeat (rhr_pkg::LATENCY + 2) @(posedge clk);
        if (err_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #5ms;
        $display("testbench: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/rhr_pkg.sv
rtl/core/rhr_front.sv
rtl/core/rhr_divider.sv
rtl/core/rhr_rebuild.sv
rtl/core/rgb_hue_rotation.sv
dv/testbench.sv
